/* sv/caa_pkg.sv */
// ----------------------------------------------------------------------------
// caa_pkg
// Shared constants, types and tables for the coarse atan2 angle unit.
// ----------------------------------------------------------------------------
package caa_pkg;

  localparam int IN_W     = 11;  // component width, two's complement
  localparam int MAG_W    = 11;  // magnitude width, holds 1024
  localparam int ANGLE_W  = 13;  // angle width, two's complement
  localparam int NUM_BNDS = 9;   // band upper bounds
  localparam int BAND_W   = 4;   // band index 0..9
  localparam int BND_W    = 9;   // widest bound is 365
  localparam int PROD_W   = BND_W + MAG_W;  // bound * |adj|

  localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(1225);
  localparam logic [ANGLE_W-1:0] HALF    = ANGLE_W'(2450);

  // sign and special-case flags carried down the pipe
  typedef struct packed {
    logic opp_pos;   // opposite > 0
    logic adj_zero;  // adjacent == 0
    logic adj_neg;   // adjacent < 0
  } caa_ctl_t;

  function automatic logic [BND_W-1:0] band_bound(input logic [BAND_W-1:0] idx);
    logic [BND_W-1:0] b;
    case (idx)
      4'd0:    b = 9'd3;
      4'd1:    b = 9'd9;
      4'd2:    b = 9'd15;
      4'd3:    b = 9'd22;
      4'd4:    b = 9'd32;
      4'd5:    b = 9'd45;
      4'd6:    b = 9'd69;
      4'd7:    b = 9'd120;
      default: b = 9'd365;
    endcase
    return b;
  endfunction

  function automatic logic [ANGLE_W-1:0] mag_pos(input logic [BAND_W-1:0] band);
    logic [ANGLE_W-1:0] m;
    case (band)
      4'd0:    m = 13'd0;
      4'd1:    m = 13'd137;
      4'd2:    m = 13'd274;
      4'd3:    m = 13'd411;
      4'd4:    m = 13'd548;
      4'd5:    m = 13'd685;
      4'd6:    m = 13'd822;
      4'd7:    m = 13'd959;
      4'd8:    m = 13'd1096;
      default: m = 13'd1225;
    endcase
    return m;
  endfunction

  function automatic logic [ANGLE_W-1:0] mag_neg(input logic [BAND_W-1:0] band);
    logic [ANGLE_W-1:0] m;
    case (band)
      4'd0:    m = 13'd2450;
      4'd1:    m = 13'd2313;
      4'd2:    m = 13'd2176;
      4'd3:    m = 13'd2039;
      4'd4:    m = 13'd1902;
      4'd5:    m = 13'd1765;
      4'd6:    m = 13'd1628;
      4'd7:    m = 13'd1493;
      4'd8:    m = 13'd1356;
      default: m = 13'd1225;
    endcase
    return m;
  endfunction

endpackage

/* sv/caa_band_cmp.sv */
// ----------------------------------------------------------------------------
// caa_band_cmp
// Band compare stage: tests 32*|opp| >= bound*|adj| for every band bound,
// which equals trunc(32*|opp|/|adj|) >= bound without a divider.
// ----------------------------------------------------------------------------
module caa_band_cmp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            valid_i,
  input  logic [caa_pkg::MAG_W-1:0]       mo_i,
  input  logic [caa_pkg::MAG_W-1:0]       ma_i,
  input  caa_pkg::caa_ctl_t               ctl_i,
  output logic                            valid_o,
  output logic [caa_pkg::NUM_BNDS-1:0]    ge_o,
  output caa_pkg::caa_ctl_t               ctl_o
);

  logic                          valid_r;
  logic [caa_pkg::NUM_BNDS-1:0]  ge_r, ge_nxt;
  caa_pkg::caa_ctl_t             ctl_r;
  logic [caa_pkg::PROD_W-1:0]    num;

  // scaled opposite, zero-extended to the product width
  assign num = caa_pkg::PROD_W'({mo_i, 5'b00000});

  always_comb begin
    for (int i = 0; i < caa_pkg::NUM_BNDS; i++) begin
      ge_nxt[i] = num >= (caa_pkg::PROD_W'(caa_pkg::band_bound(caa_pkg::BAND_W'(i)))
                          * caa_pkg::PROD_W'(ma_i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    ge_r  <= ge_nxt;
    ctl_r <= ctl_i;
  end

  assign valid_o = valid_r;
  assign ge_o    = ge_r;
  assign ctl_o   = ctl_r;

endmodule

/* sv/coarse_atan2_angle_unit.sv */
// ----------------------------------------------------------------------------
// coarse_atan2_angle_unit
// Coarse table arctangent of a signed opposite/adjacent pair, 4900 units
// per full circle.
// ----------------------------------------------------------------------------
//  channel  ports                               handshake
//  input    in_opposite, in_adjacent            start && !busy
//  result   out_angle                           out_valid, one cycle
//
//  One beat enters per cycle; busy is always low.
//  Pipeline stages: magnitude stage, band compare stage, table stage.
//  Reset clears the valid pipeline only; no data state survives an item.
//  The receiver cannot stall, so each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module coarse_atan2_angle_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [caa_pkg::IN_W-1:0]    in_opposite,
  input  logic signed [caa_pkg::IN_W-1:0]    in_adjacent,
  output logic                               out_valid,
  output logic signed [caa_pkg::ANGLE_W-1:0] out_angle
);

  logic                          s1_valid_r;
  logic [caa_pkg::MAG_W-1:0]     mo_r, mo_nxt, ma_r, ma_nxt;
  caa_pkg::caa_ctl_t             s1_ctl_r, s1_ctl_nxt;

  logic                          s2_valid;
  logic [caa_pkg::NUM_BNDS-1:0]  s2_ge;
  caa_pkg::caa_ctl_t             s2_ctl;

  logic                          out_valid_r;
  logic [caa_pkg::ANGLE_W-1:0]   angle_r, angle_nxt;
  logic [caa_pkg::BAND_W-1:0]    band;
  logic [caa_pkg::ANGLE_W-1:0]   mag;

  assign busy = 1'b0;

  // stage 1: magnitudes and sign flags
  always_comb begin
    mo_nxt = in_opposite[caa_pkg::IN_W-1] ? caa_pkg::MAG_W'(~in_opposite + 1'b1)
                                          : caa_pkg::MAG_W'(in_opposite);
    ma_nxt = in_adjacent[caa_pkg::IN_W-1] ? caa_pkg::MAG_W'(~in_adjacent + 1'b1)
                                          : caa_pkg::MAG_W'(in_adjacent);
    s1_ctl_nxt.opp_pos  = !in_opposite[caa_pkg::IN_W-1] && (in_opposite != '0);
    s1_ctl_nxt.adj_zero = (in_adjacent == '0);
    s1_ctl_nxt.adj_neg  = in_adjacent[caa_pkg::IN_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mo_r     <= mo_nxt;
    ma_r     <= ma_nxt;
    s1_ctl_r <= s1_ctl_nxt;
  end

  // stage 2: band compares
  caa_band_cmp u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid_r),
    .mo_i    (mo_r),
    .ma_i    (ma_r),
    .ctl_i   (s1_ctl_r),
    .valid_o (s2_valid),
    .ge_o    (s2_ge),
    .ctl_o   (s2_ctl)
  );

  // stage 3: band index, table lookup, sign
  always_comb begin
    // compares form a thermometer code, so the count is the band
    band = caa_pkg::BAND_W'($countones(s2_ge));
    mag  = s2_ctl.adj_neg ? caa_pkg::mag_neg(band) : caa_pkg::mag_pos(band);
    if (s2_ctl.adj_zero) begin
      angle_nxt = s2_ctl.opp_pos ? caa_pkg::QUARTER : -caa_pkg::QUARTER;
    end else if (band == '0) begin
      angle_nxt = s2_ctl.adj_neg ? caa_pkg::HALF : '0;
    end else begin
      angle_nxt = s2_ctl.opp_pos ? mag : -mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = $signed(angle_r);

  // a result beat only follows an accepted beat, through each stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result beat without matching input beat");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle >= -13'sd2450) && (out_angle <= 13'sd2450))
    else $error("angle out of range");

  a_zero_adj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_adjacent, 3) == '0)
      |-> (out_angle == 13'sd1225) || (out_angle == -13'sd1225))
    else $error("zero adjacent did not give a quarter turn");

  a_zero_opp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_opposite, 3) == '0) && ($past(in_adjacent, 3) != '0)
      |-> (out_angle == 13'sd0) || (out_angle == 13'sd2450))
    else $error("zero opposite did not land in band zero");

endmodule
